>>> src/rbd_pkg.sv
// Shared constants, types and command codes for the ring buffer deque.
package rbd_pkg;

    // Capacity and element width of the ring store.
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    // Derived widths.
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Fixed widths of the request and response fields.
    localparam int MODE_W   = 4;
    localparam int IDX_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 4'd0,
        MODE_PUSH_FRONT = 4'd1,
        MODE_POP_BACK   = 4'd2,
        MODE_POP_FRONT  = 4'd3,
        MODE_INSERT     = 4'd4,
        MODE_REMOVE     = 4'd5,
        MODE_GET        = 4'd6,
        MODE_FRONT      = 4'd7,
        MODE_BACK       = 4'd8
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   index;
        logic [VALUE_W-1:0] value;
        logic               use_zero;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_READ,
        OP_FAIL_RANGE,
        OP_FAIL_FULL,
        OP_INS_START,
        OP_RM_START,
        OP_CAPTURE,
        OP_SHIFT,
        OP_INS_END,
        OP_RM_END,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              idx_above;
        logic              idx_at;
        logic              empty;
        logic              full;
        logic              left_zero;
        logic              pend;
        logic              out_free;
    } dp_sts_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CAPTURE,
        S_RM_CAP,
        S_SHIFT,
        S_RESP
    } state_t;

endpackage

>>> src/ring_buffer_deque.sv
// Top level of the ring buffer deque: controller and datapath.
//
// A double-ended queue of DEPTH elements held in a ring store (a small RAM)
// addressed by a head pointer and a fill count. Each request word on the req
// channel (valid/ready) carries a mode, an index, a value and a zero flag; each
// request produces exactly one response word on the rsp channel (valid/ready)
// with the element concerned, a status code and the element count afterwards.
// Requests are handled one at a time. Once accepted, a request passes through
// the execute state and then the response state; pop, get, front and back
// pass through a capture state between the two because the store read is
// registered. Insert and remove move the later elements by one slot in the
// shift state, one element per cycle with read and write-back overlapped;
// remove first captures the removed element. The single RAM port pair
// bounds that shift rate. The response sits in an output register, so
// req_ready returns while a finished word still waits; a stalled receiver
// holds the next request in its final step until the output register is
// free. Reset empties the queue (head and count to zero) and drops any
// pending response; the store itself is not cleared, since no entry is
// read before it has been written.
module ring_buffer_deque (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rbd_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rbd_pkg::rsp_t rsp
);

    import rbd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rbd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .sts       (sts)
    );

endmodule

>>> src/rbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/rbd_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module rbd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rbd_pkg::dp_sts_t sts,
    output rbd_pkg::dp_cmd_t cmd
);

    import rbd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.mode)
                    MODE_PUSH_BACK:
                    begin
                        cmd.op     = sts.full ? OP_FAIL_FULL : OP_PUSH_BACK;
                        state_next = S_RESP;
                    end
                    MODE_PUSH_FRONT:
                    begin
                        cmd.op     = sts.full ? OP_FAIL_FULL : OP_PUSH_FRONT;
                        state_next = S_RESP;
                    end
                    MODE_POP_BACK, MODE_POP_FRONT, MODE_FRONT, MODE_BACK:
                    begin
                        if (sts.empty)
                        begin
                            cmd.op     = OP_FAIL_RANGE;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.op     = OP_READ;
                            state_next = S_CAPTURE;
                        end
                    end
                    MODE_GET:
                    begin
                        if (sts.idx_above || sts.idx_at)
                        begin
                            cmd.op     = OP_FAIL_RANGE;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.op     = OP_READ;
                            state_next = S_CAPTURE;
                        end
                    end
                    MODE_INSERT:
                    begin
                        // The index is checked before fullness.
                        if (sts.idx_above)
                        begin
                            cmd.op     = OP_FAIL_RANGE;
                            state_next = S_RESP;
                        end
                        else if (sts.full)
                        begin
                            cmd.op     = OP_FAIL_FULL;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.op     = OP_INS_START;
                            state_next = S_SHIFT;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (sts.idx_above || sts.idx_at)
                        begin
                            cmd.op     = OP_FAIL_RANGE;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.op     = OP_RM_START;
                            state_next = S_RM_CAP;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_FAIL_RANGE;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_CAPTURE:
            begin
                cmd.op     = OP_CAPTURE;
                state_next = S_RESP;
            end
            S_RM_CAP:
            begin
                cmd.op     = OP_CAPTURE;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sts.left_zero && !sts.pend)
                begin
                    cmd.op     = (sts.mode == MODE_INSERT) ? OP_INS_END : OP_RM_END;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op = OP_SHIFT;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A shift move in flight must have been issued from the shift state itself.
    a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SHIFT) |-> !sts.pend)
        else $error("shift move pending outside the shift state");

endmodule

>>> src/rbd_dpath.sv
// Datapath: request registers, head and fill pointers, ring store and result registers.
module rbd_dpath (
    input  logic             clk,
    input  logic             rst_n,
    input  rbd_pkg::dp_cmd_t cmd,
    input  rbd_pkg::req_t    req,
    input  logic             rsp_ready,
    output logic             rsp_valid,
    output rbd_pkg::rsp_t    rsp,
    output rbd_pkg::dp_sts_t sts
);

    import rbd_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // Ring slot of a logical position; head and position are both below DEPTH.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] hd,
                                                  input logic [CNT_W-1:0]  pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(hd) + SUM_W'(pos);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    logic [MODE_W-1:0]     mode_reg,     mode_next;
    logic [IDX_W-1:0]      idx_reg,      idx_next;
    logic [DATA_WIDTH-1:0] elem_reg,     elem_next;
    logic [ADDR_W-1:0]     head_reg,     head_next;
    logic [CNT_W-1:0]      fill_reg,     fill_next;
    logic [CNT_W-1:0]      src_reg,      src_next;
    logic [CNT_W-1:0]      dst_reg,      dst_next;
    logic [CNT_W-1:0]      left_reg,     left_next;
    logic                  pend_reg,     pend_next;
    logic [DATA_WIDTH-1:0] res_data_reg, res_data_next;
    status_t               res_status_reg, res_status_next;
    rsp_t                  out_reg,      out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [CNT_W-1:0]      idx_pos;
    logic [CNT_W-1:0]      fill_m1;
    logic [ADDR_W-1:0]     head_inc;
    logic [ADDR_W-1:0]     head_dec;
    logic                  ins;

    assign idx_pos  = CNT_W'(idx_reg);
    assign fill_m1  = fill_reg - 1'b1;
    assign head_inc = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - 1'b1;
    assign ins      = (mode_reg == MODE_INSERT);

    assign sts.mode      = mode_reg;
    assign sts.idx_above = CMP_W'(idx_reg) > CMP_W'(fill_reg);
    assign sts.idx_at    = CMP_W'(idx_reg) == CMP_W'(fill_reg);
    assign sts.empty     = (fill_reg == '0);
    assign sts.full      = (fill_reg == CNT_W'(DEPTH));
    assign sts.left_zero = (left_reg == '0);
    assign sts.pend      = pend_reg;
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        elem_next       = elem_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        left_next       = left_reg;
        pend_next       = 1'b0;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = elem_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        case (cmd.op)
            OP_LOAD:
            begin
                mode_next = req.mode;
                idx_next  = req.index;
                elem_next = req.use_zero ? '0 : DATA_WIDTH'(req.value);
            end
            OP_PUSH_BACK:
            begin
                wr_en           = 1'b1;
                wr_addr         = slot_of(head_reg, fill_reg);
                fill_next       = fill_reg + 1'b1;
                res_data_next   = elem_reg;
                res_status_next = ST_OK;
            end
            OP_PUSH_FRONT:
            begin
                wr_en           = 1'b1;
                wr_addr         = head_dec;
                head_next       = head_dec;
                fill_next       = fill_reg + 1'b1;
                res_data_next   = elem_reg;
                res_status_next = ST_OK;
            end
            OP_READ:
            begin
                rd_en           = 1'b1;
                res_status_next = ST_OK;
                case (mode_reg)
                    MODE_POP_BACK:
                    begin
                        rd_addr   = slot_of(head_reg, fill_m1);
                        fill_next = fill_m1;
                    end
                    MODE_BACK:
                    begin
                        rd_addr = slot_of(head_reg, fill_m1);
                    end
                    MODE_POP_FRONT:
                    begin
                        rd_addr   = head_reg;
                        head_next = head_inc;
                        fill_next = fill_m1;
                    end
                    MODE_FRONT:
                    begin
                        rd_addr = head_reg;
                    end
                    default:
                    begin
                        rd_addr = slot_of(head_reg, idx_pos);
                    end
                endcase
            end
            OP_FAIL_RANGE:
            begin
                res_data_next   = '0;
                res_status_next = ST_RANGE;
            end
            OP_FAIL_FULL:
            begin
                res_data_next   = '0;
                res_status_next = ST_FULL;
            end
            OP_INS_START:
            begin
                src_next        = fill_m1;
                left_next       = fill_reg - idx_pos;
                res_data_next   = elem_reg;
                res_status_next = ST_OK;
            end
            OP_RM_START:
            begin
                rd_en           = 1'b1;
                rd_addr         = slot_of(head_reg, idx_pos);
                src_next        = idx_pos + 1'b1;
                left_next       = fill_m1 - idx_pos;
                res_status_next = ST_OK;
            end
            OP_CAPTURE:
            begin
                res_data_next = rd_data;
            end
            OP_SHIFT:
            begin
                // Write back the element read last cycle while reading the next.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_of(head_reg, dst_reg);
                    wr_data = rd_data;
                end
                if (left_reg != '0)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = slot_of(head_reg, src_reg);
                    left_next = left_reg - 1'b1;
                    pend_next = 1'b1;
                    dst_next  = ins ? src_reg + 1'b1 : src_reg - 1'b1;
                    src_next  = ins ? src_reg - 1'b1 : src_reg + 1'b1;
                end
            end
            OP_INS_END:
            begin
                wr_en     = 1'b1;
                wr_addr   = slot_of(head_reg, idx_pos);
                fill_next = fill_reg + 1'b1;
            end
            OP_RM_END:
            begin
                fill_next = fill_m1;
            end
            OP_EMIT:
            begin
                out_next.data   = VALUE_W'(res_data_reg);
                out_next.status = res_status_reg;
                out_next.count  = COUNT_W'(fill_reg);
                out_valid_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        elem_reg       <= elem_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        left_reg       <= left_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // During a shift the write-back and the next read never hit the same slot.
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("store read and write collide on one slot");

    // The element count moves by at most one per cycle.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == $past(fill_reg)) ||
        (fill_reg == $past(fill_reg) + 1'b1) ||
        (fill_reg == $past(fill_reg) - 1'b1))
        else $error("fill count jumped by more than one");

    // Pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= CNT_W'(DEPTH)) && (head_reg <= ADDR_W'(DEPTH - 1)))
        else $error("head or fill outside the ring");

endmodule

>>> tb/ring_buffer_deque_tb.sv
// Self-checking testbench for the ring buffer deque: directed table, random phases, predictor.
module ring_buffer_deque_tb;
    import rbd_pkg::*;

    // Mode codes that the block does not implement and must refuse.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd9;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;

    // A word-by-word run stays far below this ceiling, even with every insert
    // shifting the whole store and every idle and hold-off counted, so the
    // ceiling only trips if the block hangs.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 80;
    localparam int TAIL_CYCLES   = 3 * (DEPTH + 6);
    localparam int PHASE_WORDS   = 40;
    localparam int PHASE_COUNT   = 15;
    localparam int MAX_REPORTS   = 10;

    // Bias of a random phase: grow the queue, shrink it, or neither.
    typedef enum int {
        BIAS_FILL,
        BIAS_DRAIN,
        BIAS_MIXED
    } bias_t;

    // One row of the directed table. Where 'typed' is set the expected
    // response is written into the row; otherwise the predictor supplies it.
    typedef struct {
        req_t word;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    // Predictor state: a private copy of the ring store, head and fill.
    logic [VALUE_W-1:0] q_store [DEPTH];
    int unsigned        q_head = 0;
    int unsigned        q_fill = 0;

    // Responses still owed by the block, oldest first.
    rsp_t     awaited_rsp [$];
    dir_row_t dir_table [$];

    int  mismatches  = 0;
    int  rsp_seen    = 0;
    int  cycle_count = 0;
    // While calm is set neither side idles, giving a stretch at full rate.
    bit  calm        = 1'b0;

    ring_buffer_deque DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still awaited",
                     cycle_count, awaited_rsp.size());
            $display("ring_buffer_deque: mismatch");
            $finish;
        end
    end

    // Ring slot of the logical element 'logical', counted from the front.
    function automatic int unsigned ring_slot(input int unsigned logical);
        return (q_head + logical) % DEPTH;
    endfunction

    // Applies one request to the predictor state and returns the response
    // the block should give. The element width equals the value width, so
    // the value is stored as it stands.
    function automatic rsp_t predict_deque_op(input req_t w);
        rsp_t               r;
        logic [VALUE_W-1:0] elem;
        int unsigned        k;
        r        = '0;
        r.status = ST_OK;
        elem     = w.use_zero ? '0 : w.value;
        case (w.mode)
            MODE_PUSH_BACK:
                if (q_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    q_store[ring_slot(q_fill)] = elem;
                    q_fill++;
                    r.data = elem;
                end
            MODE_PUSH_FRONT:
                if (q_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    q_head = (q_head == 0) ? DEPTH - 1 : q_head - 1;
                    q_store[q_head] = elem;
                    q_fill++;
                    r.data = elem;
                end
            MODE_POP_BACK:
                if (q_fill == 0)
                    r.status = ST_RANGE;
                else
                begin
                    q_fill--;
                    r.data = q_store[ring_slot(q_fill)];
                end
            MODE_POP_FRONT:
                if (q_fill == 0)
                    r.status = ST_RANGE;
                else
                begin
                    r.data = q_store[q_head];
                    q_head = (q_head + 1) % DEPTH;
                    q_fill--;
                end
            MODE_INSERT:
                // The index is tested before fullness, so a bad index on a
                // full queue reports a range error.
                if (w.index > q_fill)
                    r.status = ST_RANGE;
                else if (q_fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (k = q_fill; k > w.index; k--)
                        q_store[ring_slot(k)] = q_store[ring_slot(k - 1)];
                    q_store[ring_slot(w.index)] = elem;
                    q_fill++;
                    r.data = elem;
                end
            MODE_REMOVE:
                if (w.index >= q_fill)
                    r.status = ST_RANGE;
                else
                begin
                    r.data = q_store[ring_slot(w.index)];
                    for (k = w.index; k + 1 < q_fill; k++)
                        q_store[ring_slot(k)] = q_store[ring_slot(k + 1)];
                    q_fill--;
                end
            MODE_GET:
                if (w.index >= q_fill)
                    r.status = ST_RANGE;
                else
                    r.data = q_store[ring_slot(w.index)];
            MODE_FRONT:
                if (q_fill == 0)
                    r.status = ST_RANGE;
                else
                    r.data = q_store[ring_slot(0)];
            MODE_BACK:
                if (q_fill == 0)
                    r.status = ST_RANGE;
                else
                    r.data = q_store[ring_slot(q_fill - 1)];
            default:
                r.status = ST_RANGE;
        endcase
        r.count = q_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t dir_row(input logic [MODE_W-1:0] mode,
                                         input int unsigned index,
                                         input logic [VALUE_W-1:0] value,
                                         input bit use_zero,
                                         input bit typed,
                                         input logic [VALUE_W-1:0] data,
                                         input status_t status,
                                         input int unsigned count);
        dir_row_t row;
        row.word.mode     = mode;
        row.word.index    = index[IDX_W-1:0];
        row.word.value    = value;
        row.word.use_zero = use_zero;
        row.typed         = typed;
        row.want.data     = data;
        row.want.status   = status;
        row.want.count    = count[COUNT_W-1:0];
        return row;
    endfunction

    // Builds a random request. The bias tilts the mix towards growing or
    // shrinking the queue so that both the full and the empty state are
    // reached again and again; most indices are legal for the current fill.
    function automatic req_t random_request(input bias_t bias);
        req_t        w;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            w.mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
        else if (bias == BIAS_FILL && roll < 63)
            w.mode = (roll < 33)
                     ? MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_PUSH_BACK))
                     : MODE_INSERT;
        else if (bias == BIAS_DRAIN && roll < 63)
            w.mode = (roll < 33)
                     ? MODE_W'($urandom_range(MODE_POP_FRONT, MODE_POP_BACK))
                     : MODE_REMOVE;
        else
            w.mode = MODE_W'($urandom_range(MODE_BACK, MODE_PUSH_BACK));

        if ($urandom_range(99) < 20)
            w.index = IDX_W'($urandom_range(DEPTH, 0));
        else if (w.mode == MODE_INSERT)
            w.index = IDX_W'($urandom_range(q_fill, 0));
        else if (q_fill > 0)
            w.index = IDX_W'($urandom_range(q_fill - 1, 0));
        else
            w.index = IDX_W'($urandom_range(DEPTH, 0));

        roll = $urandom_range(99);
        if (roll < 5)
            w.value = '0;
        else if (roll < 10)
            w.value = '1;
        else
            w.value = $urandom;
        w.use_zero = ($urandom_range(99) < 10);
        return w;
    endfunction

    // Offers one request word, holding it until the block takes it, then
    // records the response it should produce. Random idle cycles go before
    // the word; when none is drawn valid simply stays high for the next one.
    task automatic send_request(input req_t w, input bit typed, input rsp_t want);
        rsp_t predicted;
        while (!calm && $urandom_range(99) < 7)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = predict_deque_op(w);
        awaited_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic log_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"%s at cycle %0d: expected data %h status %0d count %0d,",
                      " got data %h status %0d count %0d"},
                     what, cycle_count, want.data, want.status, want.count,
                     got.data, got.status, got.count);
    endtask

    // Response checker: every accepted word is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (awaited_rsp.size() == 0)
                log_mismatch("unexpected response", '0, rsp);
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.data !== want.data || rsp.status !== want.status
                    || rsp.count !== want.count)
                    log_mismatch("response mismatch", want, rsp);
            end
        end
    end

    // Receiver. It idles now and then, and twice it holds off for a long
    // stretch so that the output register fills and the block has to stall
    // its input while the sender keeps offering words.
    initial
    begin
        bit held_first;
        bit held_second;
        held_first  = 1'b0;
        held_second = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((!held_first && rsp_seen >= 150) || (!held_second && rsp_seen >= 420))
            begin
                if (!held_first)
                    held_first = 1'b1;
                else
                    held_second = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            rsp_ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    // Main sequence: reset, the directed table, then the random phases.
    initial
    begin
        req_t  w;
        bias_t bias;
        int    phase;
        int    n;

        // Empty queue: every read or removal is refused.
        dir_table.push_back(dir_row(MODE_POP_BACK,  0, '0, 0, 1, '0, ST_RANGE, 0));
        dir_table.push_back(dir_row(MODE_POP_FRONT, 0, '0, 0, 1, '0, ST_RANGE, 0));
        dir_table.push_back(dir_row(MODE_FRONT,     0, '0, 0, 1, '0, ST_RANGE, 0));
        dir_table.push_back(dir_row(MODE_BACK,      0, '0, 0, 1, '0, ST_RANGE, 0));
        dir_table.push_back(dir_row(MODE_GET,       0, '0, 0, 1, '0, ST_RANGE, 0));
        dir_table.push_back(dir_row(MODE_REMOVE,    0, '0, 0, 1, '0, ST_RANGE, 0));
        // Insert beyond the end of an empty queue.
        dir_table.push_back(dir_row(MODE_INSERT,    1, 32'h1111_1111, 0, 1, '0, ST_RANGE, 0));
        // Unimplemented modes.
        dir_table.push_back(dir_row(MODE_SPARE_LO,  0, 32'h2222_2222, 0, 1, '0, ST_RANGE, 0));
        dir_table.push_back(dir_row(MODE_SPARE_HI, 16, '1, 1, 1, '0, ST_RANGE, 0));
        // Pushes with the extreme values and with the zero flag.
        dir_table.push_back(dir_row(MODE_PUSH_BACK,  0, '1, 0, 1, '1, ST_OK, 1));
        dir_table.push_back(dir_row(MODE_PUSH_FRONT, 0, '0, 0, 1, '0, ST_OK, 2));
        dir_table.push_back(dir_row(MODE_PUSH_BACK,  0, 32'hA5A5_A5A5, 1, 1, '0, ST_OK, 3));
        // Insert at the end appends; insert at the front and in the middle.
        dir_table.push_back(dir_row(MODE_INSERT, 3, 32'h1234_5678, 0, 1,
                                    32'h1234_5678, ST_OK, 4));
        dir_table.push_back(dir_row(MODE_INSERT, 0, 32'h8000_0001, 0, 1,
                                    32'h8000_0001, ST_OK, 5));
        dir_table.push_back(dir_row(MODE_INSERT, 2, 32'h5A5A_5A5A, 1, 0, '0, ST_OK, 0));
        // Index out of range well past the end and just past the end.
        dir_table.push_back(dir_row(MODE_GET,    16, '0, 0, 1, '0, ST_RANGE, 6));
        dir_table.push_back(dir_row(MODE_REMOVE,  6, '0, 0, 1, '0, ST_RANGE, 6));
        // Reads and a middle removal, left to the predictor.
        dir_table.push_back(dir_row(MODE_GET,     5, '0, 0, 0, '0, ST_OK, 0));
        dir_table.push_back(dir_row(MODE_REMOVE,  2, '0, 0, 0, '0, ST_OK, 0));
        dir_table.push_back(dir_row(MODE_FRONT,   0, '0, 0, 0, '0, ST_OK, 0));
        dir_table.push_back(dir_row(MODE_BACK,    0, '0, 0, 0, '0, ST_OK, 0));
        dir_table.push_back(dir_row(MODE_INSERT,  6, 32'h3333_3333, 0, 1, '0, ST_RANGE, 5));
        dir_table.push_back(dir_row(MODE_POP_FRONT, 0, '0, 0, 0, '0, ST_OK, 0));
        dir_table.push_back(dir_row(MODE_POP_BACK,  0, '0, 0, 0, '0, ST_OK, 0));
        dir_table.push_back(dir_row(MODE_PUSH_FRONT, 0, 32'h0000_FFFF, 0, 0, '0, ST_OK, 0));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_request(dir_table[i].word, dir_table[i].typed, dir_table[i].want);

        // Random phases take turns at growing, shrinking and mixing, so the
        // queue runs repeatedly between empty and full. Two phases in the
        // middle run with no idling on either side.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            bias = bias_t'(phase % 3);
            calm = (phase == 6 || phase == 7);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                w = random_request(bias);
                send_request(w, 1'b0, '0);
            end
        end
        calm      = 1'b0;
        req_valid <= 1'b0;

        // Drain: wait for every awaited word, then a tail long enough for
        // a stray extra response to show itself.
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("ring_buffer_deque: match");
        else
            $display("ring_buffer_deque: mismatch");
        $finish;
    end

endmodule
